FILE: rtl/bnlf_pkg.sv
// Shared types and constants for the binary neighborhood lookup filter.
package bnlf_pkg;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  localparam int TABLE_WORDS     = 8;
  localparam int TABLE_WORD_BITS = 64;
  localparam int TABLE_IDX_BITS  = 3;
  localparam int CODE_BITS       = 9;
  localparam int OUT_COUNT_BITS  = 16;
  localparam int CFG_ADDR_BITS   = 6;

  localparam logic [CODE_BITS-1:0] TOP_MID_BOT_LEFT_MASK = 9'h1B6;
  localparam logic [CODE_BITS-1:0] RIGHT_COLUMN_MASK     = 9'h049;

  localparam logic [OUT_COUNT_BITS-1:0] OUT_COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic upper;
    logic lower;
  } line_word_t;

endpackage

FILE: rtl/binary_neighborhood_lut_filter.sv
// Streaming 3x3 binary neighborhood filter with a 512-entry rule table.
// Path: a word is held in the input register, and its result is then registered in the
//   output register; results trail the pixel stream by row width + 1 raster positions.
// Throughput: one word per cycle unless the output stalls, set by the single position
//   update on the line memory; a drain word is held until the window is full.
// Reset: synchronous, active low; clears control state, rule table and background.
//   The line memory is not swept: a row counter masks entries not yet written this frame.
module binary_neighborhood_lut_filter
  import bnlf_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int COUNT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,

  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_operation,
  input  logic                       in_pixel_in,
  input  logic                       in_row_end,
  input  logic                       in_frame_end,

  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_pixel_out,
  output logic                       out_row_last,
  output logic                       out_frame_last,
  output logic [OUT_COUNT_BITS-1:0]  out_lit_count,

  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [CFG_ADDR_BITS-1:0]   paddr,
  input  logic [TABLE_WORD_BITS-1:0] pwdata,
  output logic [TABLE_WORD_BITS-1:0] prdata,
  output logic                       pready
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RWW = $clog2(MAX_WIDTH + 1);
  localparam int FW  = $clog2(MAX_WIDTH + 3);

  // input register
  logic                       in_vld_r;
  op_t                        in_op_r;
  logic                       in_pix_r;
  logic                       in_rend_r;
  logic                       in_fend_r;

  // rule table
  logic [TABLE_WORD_BITS-1:0] table_r [TABLE_WORDS];

  // line memory
  line_word_t                 mem_r [MAX_WIDTH];
  line_word_t                 rd_r;

  // frame state
  logic [CODE_BITS-1:0]       win_r, win_nxt;
  logic [RWW-1:0]             row_width_r, row_width_nxt;
  logic [CW-1:0]              column_r, column_nxt;
  logic [FW-1:0]              pending_r, pending_nxt;
  logic                       bg_r, bg_nxt;
  logic [COUNT_BITS-1:0]      lit_r, lit_nxt;
  logic [FW-1:0]              fill_r, fill_nxt;
  logic                       flushing_r, flushing_nxt;
  logic [1:0]                 rows_seen_r, rows_seen_nxt;

  // output register
  logic                       out_vld_r;
  logic                       out_pix_r;
  logic                       out_rlast_r;
  logic                       out_flast_r;
  logic [OUT_COUNT_BITS-1:0]  out_count_r;

  logic                       out_free;
  logic                       go;
  logic                       is_drain;
  logic                       do_adv;
  logic                       consume;
  logic                       bit_in;
  logic                       up_eff;
  logic                       lo_eff;
  logic [FW-1:0]              fill_inc;
  logic                       ready;
  logic [CODE_BITS-1:0]       col_bits;
  logic [CODE_BITS-1:0]       shifted;
  logic [CODE_BITS-1:0]       code;
  logic                       emit;
  logic                       rowlast;
  logic [RWW-1:0]             k_p1;
  logic [FW-1:0]              pend_a;
  logic [FW-1:0]              pend_b;
  logic                       flush_eff;
  logic                       px;
  logic                       frame_done;
  logic [31:0]                lit_ext;
  logic                       cfg_wr;
  logic [TABLE_IDX_BITS-1:0]  cfg_idx;

  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[CFG_ADDR_BITS-1 -: TABLE_IDX_BITS];
  assign pready  = 1'b1;
  assign prdata  = table_r[cfg_idx];

  always_comb begin
    out_free  = !out_vld_r || !out_stall;
    go        = in_vld_r && out_free;
    is_drain  = (in_op_r == OP_DRAIN);
    do_adv    = go && (is_drain ? (flushing_r && (pending_r != '0)) : !flushing_r);
    bit_in    = is_drain ? bg_r : in_pix_r;

    up_eff    = (rows_seen_r >= 2'd2) ? rd_r.upper : bg_r;
    lo_eff    = (rows_seen_r >= 2'd1) ? rd_r.lower : bg_r;

    fill_inc  = (fill_r < FW'(MAX_WIDTH + 2)) ? fill_r + FW'(1) : fill_r;
    ready     = (row_width_r != '0) && (fill_inc >= FW'(row_width_r) + FW'(2));

    col_bits  = '0;
    col_bits[6] = up_eff;
    col_bits[3] = lo_eff;
    col_bits[0] = bit_in;
    shifted   = (win_r << 1) & TOP_MID_BOT_LEFT_MASK;

    if (column_r == '0) begin
      code    = shifted | (bg_r ? RIGHT_COLUMN_MASK : '0);
      rowlast = 1'b1;
      emit    = ready;
      win_nxt = (bg_r ? TOP_MID_BOT_LEFT_MASK : '0) | col_bits;
    end else begin
      win_nxt = shifted | col_bits;
      code    = win_nxt;
      rowlast = 1'b0;
      emit    = ready;
    end

    k_p1          = RWW'(column_r) + RWW'(1);
    row_width_nxt = row_width_r;
    if (row_width_r == '0) begin
      if ((!is_drain && (in_rend_r || in_fend_r)) || (k_p1 >= RWW'(MAX_WIDTH))) begin
        row_width_nxt = k_p1;
        column_nxt    = '0;
      end else begin
        column_nxt    = CW'(k_p1);
      end
    end else begin
      column_nxt = (k_p1 >= row_width_r) ? '0 : CW'(k_p1);
    end

    rows_seen_nxt = rows_seen_r;
    if (column_nxt == '0 && rows_seen_r != 2'd2) begin
      rows_seen_nxt = rows_seen_r + 2'd1;
    end

    pend_a    = pending_r + (is_drain ? FW'(0) : FW'(1));
    pend_b    = (emit && pend_a != '0) ? pend_a - FW'(1) : pend_a;
    flush_eff = flushing_r || (!is_drain && in_fend_r);

    px        = table_r[code[CODE_BITS-1 -: TABLE_IDX_BITS]][code[5:0]];
    lit_nxt   = (emit && px && (lit_r != {COUNT_BITS{1'b1}})) ? lit_r + COUNT_BITS'(1)
                                                               : lit_r;
    lit_ext   = 32'(lit_nxt);

    frame_done = do_adv && emit && flush_eff && (pend_b == '0);
    consume    = go && (!do_adv || !is_drain || emit);
    in_stall   = in_vld_r && !consume;

    pending_nxt  = pend_b;
    fill_nxt     = fill_inc;
    flushing_nxt = flush_eff;
    bg_nxt       = bg_r;

    if (frame_done) begin
      bg_nxt        = bg_r ? table_r[TABLE_WORDS-1][TABLE_WORD_BITS-1] : table_r[0][0];
      win_nxt       = '0;
      row_width_nxt = '0;
      column_nxt    = '0;
      pending_nxt   = '0;
      lit_nxt       = '0;
      fill_nxt      = '0;
      flushing_nxt  = 1'b0;
      rows_seen_nxt = '0;
    end

    if (!do_adv) begin
      win_nxt       = win_r;
      row_width_nxt = row_width_r;
      column_nxt    = column_r;
      pending_nxt   = pending_r;
      lit_nxt       = lit_r;
      fill_nxt      = fill_r;
      flushing_nxt  = flushing_r;
      rows_seen_nxt = rows_seen_r;
      bg_nxt        = bg_r;
    end
  end

  // line memory: write the current column, read the next one
  always_ff @(posedge clk) begin
    if (do_adv) begin
      mem_r[column_r] <= '{upper: lo_eff, lower: bit_in};
    end
    if (do_adv && column_nxt == column_r) begin
      rd_r <= '{upper: lo_eff, lower: bit_in};
    end else begin
      rd_r <= mem_r[column_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      win_r       <= '0;
      row_width_r <= '0;
      column_r    <= '0;
      pending_r   <= '0;
      bg_r        <= 1'b0;
      lit_r       <= '0;
      fill_r      <= '0;
      flushing_r  <= 1'b0;
      rows_seen_r <= '0;
      for (int i = 0; i < TABLE_WORDS; i++) begin
        table_r[i] <= '0;
      end
    end else begin
      if (in_valid && !in_stall) begin
        in_vld_r  <= 1'b1;
        in_op_r   <= op_t'(in_operation);
        in_pix_r  <= in_pixel_in;
        in_rend_r <= in_row_end;
        in_fend_r <= in_frame_end;
      end else if (consume) begin
        in_vld_r  <= 1'b0;
      end

      if (do_adv && emit) begin
        out_vld_r   <= 1'b1;
        out_pix_r   <= px;
        out_rlast_r <= rowlast || frame_done;
        out_flast_r <= frame_done;
        if (!frame_done) begin
          out_count_r <= '0;
        end else if (lit_ext > 32'(OUT_COUNT_MAX)) begin
          out_count_r <= OUT_COUNT_MAX;
        end else begin
          out_count_r <= lit_ext[OUT_COUNT_BITS-1:0];
        end
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end

      win_r       <= win_nxt;
      row_width_r <= row_width_nxt;
      column_r    <= column_nxt;
      pending_r   <= pending_nxt;
      bg_r        <= bg_nxt;
      lit_r       <= lit_nxt;
      fill_r      <= fill_nxt;
      flushing_r  <= flushing_nxt;
      rows_seen_r <= rows_seen_nxt;

      if (cfg_wr) begin
        table_r[cfg_idx] <= pwdata;
      end
    end
  end

  assign out_valid      = out_vld_r;
  assign out_pixel_out  = out_pix_r;
  assign out_row_last   = out_rlast_r;
  assign out_frame_last = out_flast_r;
  assign out_lit_count  = out_count_r;

  a_frame_last_row_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_last |-> out_row_last)
    else $error("frame_last word without row_last");

  a_count_only_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_last |-> out_lit_count == '0)
    else $error("nonzero lit_count outside frame end");

  a_column_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    row_width_r != '0 |-> RWW'(column_r) < row_width_r)
    else $error("column index beyond learned row width");

  a_flush_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
    flushing_r |-> pending_r != '0)
    else $error("flushing with nothing pending");

  a_frame_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |=> !flushing_r && row_width_r == '0 && out_valid && out_frame_last)
    else $error("frame end did not clear frame state");

endmodule

FILE: tb/binary_neighborhood_lut_filter_tb.sv
// Self-checking testbench for the binary 3x3 neighborhood rule-table filter.
`timescale 1ns / 1ps

module binary_neighborhood_lut_filter_tb
  import bnlf_pkg::*;
();

  localparam int MAX_W       = 256;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_PAUSE = 8;
  localparam int REG_STRIDE  = 8;
  localparam int PHASE_WORDS = 150;
  localparam logic [TABLE_WORD_BITS-1:0] CENTER_RULE = 64'hFFFF_0000_FFFF_0000;

  typedef enum int {
    RULES_ZERO,
    RULES_ONES,
    RULES_CENTER,
    RULES_RANDOM,
    RULES_SPARSE,
    RULES_DENSE
  } rule_kind_t;

  typedef struct packed {
    logic                      pixel;
    logic                      row_last;
    logic                      frame_last;
    logic [OUT_COUNT_BITS-1:0] lit;
  } filt_out_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_operation = 1'b0;
  logic                       in_pixel_in = 1'b0;
  logic                       in_row_end = 1'b0;
  logic                       in_frame_end = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_pixel_out;
  logic                       out_row_last;
  logic                       out_frame_last;
  logic [OUT_COUNT_BITS-1:0]  out_lit_count;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0]   paddr = '0;
  logic [TABLE_WORD_BITS-1:0] pwdata = '0;
  logic [TABLE_WORD_BITS-1:0] prdata;
  logic                       pready;

  logic [TABLE_WORD_BITS-1:0] rule_tbl [TABLE_WORDS];
  bit                         upper_line [MAX_W];
  bit                         lower_line [MAX_W];
  logic [CODE_BITS-1:0]       win;
  int                         row_w;
  int                         col_idx;
  int                         pending_px;
  int                         fill_cnt;
  bit                         bg;
  bit                         flush_on;
  logic [OUT_COUNT_BITS-1:0]  lit_cnt;

  filt_out_t                  filtered_q [$];
  int                         taken_words = 0;
  int                         mismatches = 0;
  int                         rx_wait = 0;
  bit                         tx_idle = 1'b1;
  bit                         rx_idle = 1'b1;

  binary_neighborhood_lut_filter uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_pixel_in    (in_pixel_in),
    .in_row_end     (in_row_end),
    .in_frame_end   (in_frame_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_out  (out_pixel_out),
    .out_row_last   (out_row_last),
    .out_frame_last (out_frame_last),
    .out_lit_count  (out_lit_count),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic bit coin();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic bit rule_bit(logic [CODE_BITS-1:0] code);
    return rule_tbl[code[8:6]][code[5:0]];
  endfunction

  function automatic void clear_frame();
    foreach (upper_line[k]) begin
      upper_line[k] = bg;
      lower_line[k] = bg;
    end
    win        = '0;
    row_w      = 0;
    col_idx    = 0;
    pending_px = 0;
    lit_cnt    = '0;
    fill_cnt   = 0;
    flush_on   = 1'b0;
  endfunction

  function automatic bit shift_in(input bit px, input bit live, input bit re, input bit fe,
                                  output logic [CODE_BITS-1:0] code, output bit rlast);
    int                   k;
    bit                   rdy;
    bit                   got;
    logic [CODE_BITS-1:0] col;
    k     = col_idx;
    got   = 1'b0;
    code  = '0;
    rlast = 1'b0;
    if (k >= MAX_W) k = 0;
    if (fill_cnt < MAX_W + 2) fill_cnt++;
    rdy = (row_w != 0) && (fill_cnt >= row_w + 2);
    if (k == 0 && rdy) begin
      code  = ((win << 1) & TOP_MID_BOT_LEFT_MASK) | (bg ? RIGHT_COLUMN_MASK : '0);
      rlast = 1'b1;
      got   = 1'b1;
    end
    col = {2'b00, upper_line[k], 2'b00, lower_line[k], 2'b00, px};
    upper_line[k] = lower_line[k];
    lower_line[k] = px;
    if (k == 0) begin
      win = (bg ? TOP_MID_BOT_LEFT_MASK : '0) | col;
    end else begin
      win = ((win << 1) & TOP_MID_BOT_LEFT_MASK) | col;
      if (rdy) begin
        code  = win;
        rlast = 1'b0;
        got   = 1'b1;
      end
    end
    if (row_w == 0) begin
      if ((live && (re || fe)) || k + 1 >= MAX_W) begin
        row_w   = k + 1;
        col_idx = 0;
      end else begin
        col_idx = k + 1;
      end
    end else begin
      col_idx = (k + 1 >= row_w) ? 0 : k + 1;
    end
    return got;
  endfunction

  function automatic void emit_pixel(logic [CODE_BITS-1:0] code, bit rlast);
    filt_out_t r;
    bit        px;
    px = rule_bit(code);
    if (pending_px > 0) pending_px--;
    if (px && lit_cnt != OUT_COUNT_MAX) lit_cnt++;
    r.pixel      = px;
    r.row_last   = rlast;
    r.frame_last = 1'b0;
    r.lit        = '0;
    if (flush_on && pending_px == 0) begin
      r.row_last   = 1'b1;
      r.frame_last = 1'b1;
      r.lit        = lit_cnt;
      bg = rule_bit({CODE_BITS{bg}});
      clear_frame();
    end
    filtered_q.push_back(r);
  endfunction

  // Returns 0 for a word that the filter ignores.
  function automatic bit filter_word(op_t op, bit px, bit re, bit fe);
    logic [CODE_BITS-1:0] code;
    bit                   rl;
    if (op == OP_PIXEL) begin
      if (flush_on) return 1'b0;
      pending_px++;
      if (shift_in(px, 1'b1, re, fe, code, rl)) begin
        if (fe) flush_on = 1'b1;
        emit_pixel(code, rl);
      end else if (fe) begin
        flush_on = 1'b1;
      end
      return 1'b1;
    end
    if (!flush_on || pending_px == 0) return 1'b0;
    for (int i = 0; i < MAX_W + 3; i++) begin
      if (shift_in(bg, 1'b0, 1'b0, 1'b0, code, rl)) begin
        emit_pixel(code, rl);
        return 1'b1;
      end
    end
    return 1'b1;
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : out_check
    filt_out_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (filtered_q.size() == 0) begin
        mismatches++;
        $display("%0t unexpected word: expected none, actual pixel %0d row %0d frame %0d lit %0d",
                 $time, out_pixel_out, out_row_last, out_frame_last, out_lit_count);
      end else begin
        want = filtered_q.pop_front();
        check_field("pixel_out", 32'(want.pixel), 32'(out_pixel_out));
        check_field("row_last", 32'(want.row_last), 32'(out_row_last));
        check_field("frame_last", 32'(want.frame_last), 32'(out_frame_last));
        check_field("lit_count", 32'(want.lit), 32'(out_lit_count));
      end
      rx_wait = rx_idle ? int'($urandom_range(0, 15)) : 0;
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    out_stall <= (rx_wait != 0);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || !rst_n) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_word(op_t op, bit px, bit re, bit fe);
    int gap;
    gap = tx_idle ? int'($urandom_range(0, 15)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_pixel_in  <= px;
    in_row_end   <= re;
    in_frame_end <= fe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (filter_word(op, px, re, fe)) taken_words++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_rule_word(int idx, logic [TABLE_WORD_BITS-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_BITS'(idx * REG_STRIDE);
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rule_tbl[idx] = v;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_rules(rule_kind_t kind);
    logic [TABLE_WORD_BITS-1:0] w;
    for (int i = 0; i < TABLE_WORDS; i++) begin
      case (kind)
        RULES_ZERO:   w = '0;
        RULES_ONES:   w = '1;
        RULES_CENTER: w = CENTER_RULE;
        RULES_SPARSE: w = {$urandom, $urandom} & {$urandom, $urandom};
        RULES_DENSE:  w = {$urandom, $urandom} | {$urandom, $urandom};
        default:      w = {$urandom, $urandom};
      endcase
      write_rule_word(i, w);
    end
  endtask

  task automatic flush_frame(bit noisy);
    int guard;
    guard = 0;
    while (flush_on && guard < 2 * MAX_W) begin
      if (noisy && $urandom_range(0, 19) == 0) send_word(OP_PIXEL, coin(), coin(), coin());
      send_word(OP_DRAIN, coin(), coin(), coin());
      guard++;
    end
  endtask

  task automatic send_frame(int w, int rows, int last_len, int density, bit noisy);
    bit px;
    bit re;
    bit fe;
    int len;
    for (int r = 0; r < rows; r++) begin
      len = (r == rows - 1) ? last_len : w;
      for (int c = 0; c < len; c++) begin
        px = ($urandom_range(0, 99) < density);
        fe = (r == rows - 1) && (c == len - 1);
        if (r == 0) begin
          re = (c == w - 1) && (w < MAX_W || coin());
        end else begin
          re = noisy ? ($urandom_range(0, 3) == 0) : (c == w - 1);
        end
        if (noisy && $urandom_range(0, 29) == 0) send_word(OP_DRAIN, coin(), coin(), coin());
        send_word(OP_PIXEL, px, re, fe);
      end
    end
    flush_frame(noisy);
  endtask

  task automatic test_center_pass();
    settle();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    load_rules(RULES_CENTER);
    send_word(OP_PIXEL, 1'b1, 1'b0, 1'b0);
    send_word(OP_PIXEL, 1'b0, 1'b0, 1'b0);
    send_word(OP_PIXEL, 1'b1, 1'b1, 1'b0);
    send_word(OP_PIXEL, 1'b0, 1'b0, 1'b0);
    send_word(OP_PIXEL, 1'b1, 1'b0, 1'b0);
    send_word(OP_PIXEL, 1'b1, 1'b1, 1'b1);
    flush_frame(1'b0);
  endtask

  task automatic test_short_last_row();
    settle();
    load_rules(RULES_RANDOM);
    send_word(OP_PIXEL, 1'b0, 1'b0, 1'b0);
    send_word(OP_PIXEL, 1'b1, 1'b0, 1'b0);
    send_word(OP_PIXEL, 1'b1, 1'b1, 1'b0);
    send_word(OP_PIXEL, 1'b1, 1'b0, 1'b1);
    flush_frame(1'b0);
  endtask

  task automatic test_ignored_words();
    settle();
    send_word(OP_DRAIN, 1'b1, 1'b1, 1'b1);
    send_word(OP_PIXEL, 1'b1, 1'b1, 1'b1);
    send_word(OP_PIXEL, 1'b0, 1'b0, 1'b0);
    flush_frame(1'b0);
  endtask

  task automatic test_background_swap();
    settle();
    load_rules(RULES_CENTER);
    write_rule_word(0, CENTER_RULE | 64'h1);
    send_word(OP_PIXEL, 1'b1, 1'b1, 1'b1);
    flush_frame(1'b0);
    send_word(OP_PIXEL, 1'b0, 1'b1, 1'b1);
    flush_frame(1'b0);
    settle();
    write_rule_word(TABLE_WORDS - 1, CENTER_RULE & 64'h7FFF_FFFF_FFFF_FFFF);
    send_word(OP_PIXEL, 1'b0, 1'b1, 1'b1);
    flush_frame(1'b0);
  endtask

  task automatic test_random_frames();
    int stop_at;
    int w;
    int rows;
    int last_len;
    int density;
    for (int p = 0; p < 8; p++) begin
      settle();
      load_rules(rule_kind_t'(p % 6));
      stop_at = taken_words + PHASE_WORDS;
      while (taken_words < stop_at) begin
        tx_idle  = ($urandom_range(0, 3) != 0);
        rx_idle  = ($urandom_range(0, 3) != 0);
        w        = ($urandom_range(0, 9) == 0) ? int'($urandom_range(9, 40))
                                                : int'($urandom_range(1, 8));
        rows     = $urandom_range(1, 5);
        last_len = coin() ? w : int'($urandom_range(1, w));
        case ($urandom_range(0, 3))
          0:       density = 0;
          1:       density = 100;
          default: density = $urandom_range(10, 90);
        endcase
        send_frame(w, rows, last_len, density, $urandom_range(0, 2) == 0);
      end
    end
  endtask

  task automatic test_full_width_row();
    settle();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    load_rules(RULES_RANDOM);
    send_frame(MAX_W, 2, $urandom_range(1, MAX_W), 50, 1'b1);
  endtask

  initial begin : run
    foreach (rule_tbl[i]) rule_tbl[i] = '0;
    bg = 1'b0;
    clear_frame();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_center_pass();
    test_short_last_row();
    test_ignored_words();
    test_background_swap();
    test_random_frames();
    test_full_width_row();
    settle();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
